// ===== design/mdls_pkg.sv =====
// Package for the multiplexed digit and LED ring scanner.
// Holds request codes, the glyph lookup and fixed widths; no dependencies.
`default_nettype none

package mdls_pkg;

    localparam int ROW_COUNT  = 8;
    localparam int ROW_IDX_W  = 3;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 4;
    localparam int POS_W      = 2;
    localparam int LED_IDX_W  = 6;
    localparam int SEL_W      = 4;
    localparam int DWELL_W    = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [BYTE_W-1:0] BLANK_BYTE = 8'hff;
    localparam logic [BYTE_W-1:0] LIT_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] COLON_MASK = 8'h7f;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_SET_DIGIT = 3'd1,
        REQ_LED_ON    = 3'd2,
        REQ_LED_OFF   = 3'd3,
        REQ_ALL_ON    = 3'd4,
        REQ_ALL_OFF   = 3'd5,
        REQ_SET_COLON = 3'd6
    } req_type_t;

    // Active-low seven-segment patterns; code ten and codes above eleven are dark.
    function automatic logic [BYTE_W-1:0] glyph_of(input logic [CODE_W-1:0] code);
        logic [BYTE_W-1:0] seg;
        case (code)
            4'd0:    seg = 8'hc0;
            4'd1:    seg = 8'hf9;
            4'd2:    seg = 8'ha4;
            4'd3:    seg = 8'hb0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hf8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            4'd11:   seg = 8'hc6;
            default: seg = BLANK_BYTE;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== design/multiplexed_digit_led_scanner.sv =====
// Top level of the multiplexed digit and LED ring scanner.
// Depends on mdls_pkg for request codes, glyph table and widths.
`default_nettype none

// Usage:
//  - Slave stream (s_axis_*) carries one request word per handshake. Tick
//    words produce one output word; control words (set digit, LED on/off,
//    all on/off, set colon) only update the stored picture and produce none.
//    Request type 7 is dropped silently.
//  - Master stream (m_axis_*) carries the segment byte and common select of
//    the scan phase current when the tick was taken.
//  - Throughput: one request word per cycle unless the skid is full. Each word
//    is decoded by one level of logic from stored picture to output register.
//  - A tick's word is registered in the output register, or in the skid entry.
//  - Stall: a two-entry output (register plus skid) lets a tick be taken while
//    the previous word waits; s_axis_tready drops only when both entries are
//    full and returns as soon as the receiver takes a word.
//  - Reset (rst_n low, async): digits 0, all LEDs lit, colon dark, phase 0,
//    dwell counter 0, dwell_ticks 2, output empty.
//  - cfg_wr_en/cfg_wr_data write dwell_ticks (0 acts as 1); write while idle.
//  - Phases: DIGIT_COUNT digits, eight LED rows, one blank phase.

module multiplexed_digit_led_scanner
    import mdls_pkg::*;
#(
    parameter int LED_COUNT   = 60,
    parameter int DIGIT_COUNT = 4
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] req_type, [4:3] digit_position, [8:5] digit_code,
    // [14:9] led_index, [15] colon_on
    input  wire [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // [7:0] segment_byte, [11:8] common_select, [15:12] zero
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire                    cfg_wr_en,
    input  wire [DWELL_W-1:0]      cfg_wr_data
);

    localparam int PHASE_COUNT = DIGIT_COUNT + ROW_COUNT + 1;
    localparam int PH_W        = $clog2(PHASE_COUNT);
    localparam int DIG_IW      = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [PH_W-1:0] LAST_PHASE  = PH_W'(PHASE_COUNT - 1);
    localparam logic [PH_W-1:0] ROW_START   = PH_W'(DIGIT_COUNT);
    localparam logic [PH_W-1:0] BLANK_PHASE = PH_W'(DIGIT_COUNT + ROW_COUNT);
    localparam logic [LED_IDX_W:0]   LED_LIMIT = (LED_IDX_W+1)'(LED_COUNT);
    localparam logic [LED_IDX_W-1:0] LED_WRAP  = LED_IDX_W'(LED_COUNT - 1);

    // Request fields
    logic [2:0]           req_type;
    logic [POS_W-1:0]     digit_position;
    logic [CODE_W-1:0]    digit_code;
    logic [LED_IDX_W-1:0] led_index;
    logic                 colon_on;

    assign req_type       = s_axis_tdata[2:0];
    assign digit_position = s_axis_tdata[4:3];
    assign digit_code     = s_axis_tdata[8:5];
    assign led_index      = s_axis_tdata[14:9];
    assign colon_on       = s_axis_tdata[15];

    // Stored picture and scan state
    logic [CODE_W-1:0] digit_codes_reg [DIGIT_COUNT];
    logic [CODE_W-1:0] digit_codes_next [DIGIT_COUNT];
    logic [BYTE_W-1:0] led_rows_reg [ROW_COUNT];
    logic [BYTE_W-1:0] led_rows_next [ROW_COUNT];
    logic              colon_reg, colon_next;
    logic [PH_W-1:0]   scan_phase_reg, scan_phase_next;
    logic [DWELL_W-1:0] dwell_count_reg, dwell_count_next;
    logic [DWELL_W-1:0] dwell_ticks_reg, dwell_ticks_next;

    // Output register plus skid entry
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [OUT_DATA_W-1:0] skid_data_reg, skid_data_next;

    logic                  accept;
    logic                  tick;
    logic [BYTE_W-1:0]     seg;
    logic [PH_W-1:0]       row_phase;
    logic [OUT_DATA_W-1:0] result;
    logic [LED_IDX_W-1:0]  led_pos;
    logic                  led_valid;
    logic [DWELL_W-1:0]    dwell_limit;
    logic [DWELL_W-1:0]    dwell_inc;
    logic                  dwell_done;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign tick          = accept && (req_type == REQ_TICK);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Rotate the ring by one: LED 0 sits in the last stored slot.
    assign led_valid = {1'b0, led_index} < LED_LIMIT;
    assign led_pos   = (led_index == '0) ? LED_WRAP : led_index - LED_IDX_W'(1);

    assign dwell_limit = (dwell_ticks_reg == '0) ? DWELL_W'(1) : dwell_ticks_reg;
    assign dwell_inc   = dwell_count_reg + DWELL_W'(1);
    assign dwell_done  = dwell_inc >= dwell_limit;

    // Segment byte for the current phase
    assign row_phase = scan_phase_reg - ROW_START;

    always_comb
    begin
        if (scan_phase_reg < ROW_START)
        begin
            seg = glyph_of(digit_codes_reg[scan_phase_reg[DIG_IW-1:0]]);
            if (scan_phase_reg == PH_W'(1) && colon_reg)
            begin
                seg = seg & COLON_MASK;
            end
        end
        else if (scan_phase_reg < BLANK_PHASE)
        begin
            seg = led_rows_reg[row_phase[ROW_IDX_W-1:0]];
        end
        else
        begin
            seg = BLANK_BYTE;
        end
    end

    assign result = {(OUT_DATA_W-BYTE_W-SEL_W)'(0), scan_phase_reg[SEL_W-1:0], seg};

    // Picture updates and phase advance
    always_comb
    begin
        digit_codes_next = digit_codes_reg;
        led_rows_next    = led_rows_reg;
        colon_next       = colon_reg;
        scan_phase_next  = scan_phase_reg;
        dwell_count_next = dwell_count_reg;
        dwell_ticks_next = cfg_wr_en ? cfg_wr_data : dwell_ticks_reg;

        if (accept)
        begin
            case (req_type)
                REQ_TICK:
                begin
                    if (dwell_done)
                    begin
                        dwell_count_next = '0;
                        scan_phase_next  = (scan_phase_reg == LAST_PHASE) ?
                                           '0 : scan_phase_reg + PH_W'(1);
                    end
                    else
                    begin
                        dwell_count_next = dwell_inc;
                    end
                end
                REQ_SET_DIGIT:
                begin
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        if (int'(digit_position) == i)
                        begin
                            digit_codes_next[i] = digit_code;
                        end
                    end
                end
                REQ_LED_ON:
                begin
                    if (led_valid)
                    begin
                        led_rows_next[led_pos[5:3]][led_pos[2:0]] = 1'b0;
                    end
                end
                REQ_LED_OFF:
                begin
                    if (led_valid)
                    begin
                        led_rows_next[led_pos[5:3]][led_pos[2:0]] = 1'b1;
                    end
                end
                REQ_ALL_ON:
                begin
                    for (int r = 0; r < ROW_COUNT; r++)
                    begin
                        led_rows_next[r] = LIT_BYTE;
                    end
                end
                REQ_ALL_OFF:
                begin
                    for (int r = 0; r < ROW_COUNT; r++)
                    begin
                        led_rows_next[r] = BLANK_BYTE;
                    end
                end
                REQ_SET_COLON:
                begin
                    colon_next = colon_on;
                end
                default:
                begin
                    colon_next = colon_reg;
                end
            endcase
        end
    end

    // Output register and skid: order kept, skid drains first.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = tick;
                out_data_next  = result;
            end
        end
        else if (tick)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                digit_codes_reg[i] <= '0;
            end
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                led_rows_reg[r] <= LIT_BYTE;
            end
            colon_reg       <= 1'b0;
            scan_phase_reg  <= '0;
            dwell_count_reg <= '0;
            dwell_ticks_reg <= DWELL_W'(2);
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            digit_codes_reg <= digit_codes_next;
            led_rows_reg    <= led_rows_next;
            colon_reg       <= colon_next;
            scan_phase_reg  <= scan_phase_next;
            dwell_count_reg <= dwell_count_next;
            dwell_ticks_reg <= dwell_ticks_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    // Skid entry is only ever filled behind a waiting output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        scan_phase_reg <= LAST_PHASE)
        else $error("scan phase out of range");

    // Control words leave the scan position alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type != REQ_TICK)
        |=> ($stable(scan_phase_reg) && $stable(dwell_count_reg)))
        else $error("control word moved the scan");

    // Reaching the dwell limit restarts the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick && dwell_done) |=> (dwell_count_reg == '0))
        else $error("dwell count not cleared at phase advance");

    // A tick accepted into an empty output shows on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick && !out_valid_reg) |=> out_valid_reg)
        else $error("tick result lost");
`endif

endmodule

`default_nettype wire
